FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPRI   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;

  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [DATA_W-1:0]  value;
    logic [LEVEL_W-1:0] level;
  } spq_cmd_t;

endpackage

FILE: rtl/core/stable_priority_queue.sv
// Stable priority queue of signed 32-bit values with levels 1 to 5.
//
// Input channel in_*: one request per accepted item (insert, remove front,
// search value, clear). Output channel out_*: exactly one result per request,
// in request order. Both use valid/stall; an item moves when valid is high
// and stall is low.
// Entries sit in a row of CAPACITY cells sorted by level, equal levels in
// arrival order; insert and remove shift the row, all cells at once.
// An accepted request is registered and run in the execute step, which
// loads the output register; a search instead registers the per-cell
// match vector there, and the find-first stage loads its result. The
// sequencer works on one request at a time; in_stall is high while busy.
// A finished result waits in the output register while the next request
// is accepted; while out_stall holds it, a following request waits in
// the execute step (a search in the find step); the cells do not change.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared and are never read while empty.
`timescale 1ns / 1ps
module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [spq_pkg::OP_W-1:0]            in_operation,
  input  logic signed [spq_pkg::DATA_W-1:0]   in_item_value,
  input  logic [spq_pkg::LEVEL_W-1:0]         in_item_priority,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [spq_pkg::DATA_W-1:0]   out_removed_value,
  output logic [spq_pkg::LEVEL_W-1:0]         out_removed_priority,
  output logic [spq_pkg::POS_W-1:0]           out_found_position,
  output logic [spq_pkg::COUNT_W-1:0]         out_entry_count
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]     req_op_r;
  logic [DATA_W-1:0]   req_value_r;
  logic [LEVEL_W-1:0]  req_level_r;
  logic [CAPACITY-1:0] match_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_rem_value_r;
  logic [LEVEL_W-1:0]  out_rem_level_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                in_accept;
  logic                out_free;
  logic                exec_go;
  logic                out_load;
  logic                bad_level;
  logic                is_full;
  logic                is_empty;
  spq_cmd_t            cmd;

  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0]   res_rem_value;
  logic [LEVEL_W-1:0]  res_rem_level;
  logic [POS_W-1:0]    res_pos;
  logic [31:0]         count_ext;
  logic [31:0]         pos_ext;

  logic [DATA_W-1:0]   cell_value   [CAPACITY];
  logic [LEVEL_W-1:0]  cell_level   [CAPACITY];
  logic [CAPACITY-1:0] cell_greater;
  logic [CAPACITY-1:0] cell_match;

  logic                find_found;
  logic [IDX_W-1:0]    find_pos;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_go   = (state_r == S_EXEC) && ((req_op_r == OP_SEARCH) || out_free);

  assign bad_level = (req_level_r < LEVEL_MIN) || (req_level_r > LEVEL_MAX);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);

  assign cmd.ins   = exec_go && (req_op_r == OP_INSERT) && !bad_level && !is_full;
  assign cmd.rem   = exec_go && (req_op_r == OP_REMOVE) && !is_empty;
  assign cmd.value = req_value_r;
  assign cmd.level = req_level_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               lg;
    logic [DATA_W-1:0]  lv;
    logic [LEVEL_W-1:0] ll;
    logic [DATA_W-1:0]  rv;
    logic [LEVEL_W-1:0] rl;

    if (i == 0) begin : g_head
      assign lg = 1'b0;
      assign lv = '0;
      assign ll = '0;
    end else begin : g_body
      assign lg = cell_greater[i-1];
      assign lv = cell_value[i-1];
      assign ll = cell_level[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = cell_value[i];
      assign rl = cell_level[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
      assign rl = cell_level[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .count        (count_r),
      .left_greater (lg),
      .left_value   (lv),
      .left_level   (ll),
      .right_value  (rv),
      .right_level  (rl),
      .value        (cell_value[i]),
      .level        (cell_level[i]),
      .greater      (cell_greater[i]),
      .match        (cell_match[i])
    );
  end

  spq_find #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_find (
    .match (match_r),
    .found (find_found),
    .pos   (find_pos)
  );

  assign pos_ext = 32'(find_pos);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_load      = 1'b0;
    res_status    = ST_OK;
    res_rem_value = '0;
    res_rem_level = '0;
    res_pos       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          unique case (req_op_r)
            OP_INSERT: begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              priority if (bad_level) begin
                res_status = ST_BADPRI;
              end else if (is_full) begin
                res_status = ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_rem_value = cell_value[0];
                res_rem_level = cell_level[0];
                count_nxt     = count_r - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              state_nxt = S_FIND;
            end
            default: begin
              out_load   = 1'b1;
              state_nxt  = S_IDLE;
              res_status = is_empty ? ST_EMPTY : ST_OK;
              count_nxt  = '0;
            end
          endcase
        end
      end
      S_FIND: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          priority if (is_empty) begin
            res_status = ST_EMPTY;
          end else if (find_found) begin
            res_pos = pos_ext[POS_W-1:0];
          end else begin
            res_status = ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_ext = 32'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_op_r    <= in_operation;
      req_value_r <= $unsigned(in_item_value);
      req_level_r <= in_item_priority;
    end
    if (exec_go) begin
      match_r <= cell_match;
    end
    if (out_load) begin
      out_status_r    <= res_status;
      out_rem_value_r <= res_rem_value;
      out_rem_level_r <= res_rem_level;
      out_pos_r       <= res_pos;
      out_count_r     <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_removed_value    = $signed(out_rem_value_r);
  assign out_removed_priority = out_rem_level_r;
  assign out_found_position   = out_pos_r;
  assign out_entry_count      = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC) || ($past(state_r) == S_FIND))
    else $error("result raised outside execute or find step");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue by one");

  a_removed_level_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rem_level_r != '0) |-> out_status_r == ST_OK)
    else $error("removed level reported on a failed request");
`endif

endmodule

FILE: rtl/core/spq_cell.sv
// One queue slot: holds an entry and shifts toward its neighbors.
`timescale 1ns / 1ps
module spq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                         clk,
  input  spq_pkg::spq_cmd_t            cmd,
  input  logic [CNT_W-1:0]             count,
  input  logic                         left_greater,
  input  logic [spq_pkg::DATA_W-1:0]   left_value,
  input  logic [spq_pkg::LEVEL_W-1:0]  left_level,
  input  logic [spq_pkg::DATA_W-1:0]   right_value,
  input  logic [spq_pkg::LEVEL_W-1:0]  right_level,
  output logic [spq_pkg::DATA_W-1:0]   value,
  output logic [spq_pkg::LEVEL_W-1:0]  level,
  output logic                         greater,
  output logic                         match
);
  import spq_pkg::*;

  logic [DATA_W-1:0]  value_r, value_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               occupied;
  logic               at_tail;
  logic               take_new;

  assign occupied = CNT_W'(INDEX) < count;
  assign at_tail  = CNT_W'(INDEX) == count;
  assign greater  = occupied && (level_r > cmd.level);
  assign match    = occupied && (value_r == cmd.value);
  assign take_new = (greater || at_tail) && !left_greater;

  always_comb begin
    value_nxt = value_r;
    level_nxt = level_r;
    priority if (cmd.ins && left_greater) begin
      value_nxt = left_value;
      level_nxt = left_level;
    end else if (cmd.ins && take_new) begin
      value_nxt = cmd.value;
      level_nxt = cmd.level;
    end else if (cmd.rem) begin
      value_nxt = right_value;
      level_nxt = right_level;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    level_r <= level_nxt;
  end

  assign value = value_r;
  assign level = level_r;

endmodule

FILE: rtl/core/spq_find.sv
// Find-first over the registered match vector of the cell row.
`timescale 1ns / 1ps
module spq_find #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 4
) (
  input  logic [CAPACITY-1:0] match,
  output logic                found,
  output logic [IDX_W-1:0]    pos
);

  logic [CAPACITY-1:0] first;

  assign found = |match;
  assign first = match & (~match + CAPACITY'(1));

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

endmodule
